### src/hof_pkg.sv
//==============================================================================
// hof_pkg
// shared constants and types for the hampel outlier filter
//==============================================================================
`default_nettype none
package hof_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int SAMPLE_W       = 16;
  localparam int DEV_W          = 17;   // absolute deviation, unsigned
  localparam int VAL_W          = 18;   // signed working width for sorted values
  localparam int LEN_W          = 5;
  localparam int THR_W          = 8;
  localparam int LEN_RESET      = 5;
  localparam int THR_RESET      = 3;

  localparam logic [0:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [0:0] REG_THRESHOLD     = 1'd1;

  // cell control: load clears the chain, push inserts a value
  typedef struct packed {
    logic load;
    logic push;
  } cell_ctl_t;

endpackage
`default_nettype wire

### src/hampel_outlier_filter.sv
//==============================================================================
// hampel_outlier_filter
// sliding-window median / median absolute deviation outlier replacement
//==============================================================================
// usage:
//   input channel sample_valid/sample_stall carries one signed sample per item;
//   output channel filtered_valid/filtered_stall carries one result per item.
//   config: cfg_we/cfg_index/cfg_data, written while idle; writing
//   window_length restarts the window fill.
// timing:
//   per item: a write into the window store, insertion of the n window values into
//   the sorting cell row, a median read, insertion of the n absolute deviations,
//   a second median read and the compare, with n up to WINDOW_MAX.
//   with fewer than two values held the item passes straight through from idle.
//   the cell row takes one value per cycle.
//   one item is processed at a time; a new item is taken once the previous
//   result has left the output register or leaves it in the same cycle.
// reset:
//   window empty, window_length 5, threshold 3, no result pending.
//   a stalled result holds on the output until taken.
//==============================================================================
`default_nettype none
module hampel_outlier_filter #(
  parameter int WINDOW_MAX = hof_pkg::WINDOW_MAX_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [0:0]                       cfg_index,
  input  wire [7:0]                       cfg_data,
  input  wire                             sample_valid,
  output logic                            sample_stall,
  input  wire signed [hof_pkg::SAMPLE_W-1:0] sample,
  output logic                            filtered_valid,
  input  wire                             filtered_stall,
  output logic signed [hof_pkg::SAMPLE_W-1:0] filtered
);
  import hof_pkg::*;
  localparam int CW = $clog2(WINDOW_MAX+1);
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SORT1, S_MED1, S_SORT2, S_MED2, S_DONE
  } state_t;

  state_t state;
  logic [LEN_W-1:0] window_length;
  logic [THR_W-1:0] threshold;
  logic signed [SAMPLE_W-1:0] window_store [WINDOW_MAX];
  logic [IW-1:0] write_slot;
  logic window_full;
  logic [CW-1:0] count, idx;
  logic signed [SAMPLE_W-1:0] cur, rd_val;
  logic signed [VAL_W-1:0] med, mad;
  logic signed [VAL_W-1:0] new_val, chain_med;
  cell_ctl_t ctl;

  // effective length
  logic [CW-1:0] len;
  always_comb begin
    if (window_length == '0) len = CW'(1);
    else if (32'(window_length) > WINDOW_MAX) len = CW'(WINDOW_MAX);
    else len = CW'(window_length);
  end

  assign rd_val = window_store[idx[IW-1:0]];

  logic signed [VAL_W-1:0] dev;
  assign dev = VAL_W'(rd_val) - med;

  always_comb begin
    ctl.load = (state == S_MED1) || (state == S_IDLE);
    ctl.push = (state == S_SORT1) || (state == S_SORT2);
    if (state == S_SORT2) new_val = (dev < 0) ? -dev : dev;
    else new_val = VAL_W'(rd_val);
  end

  hof_sort_chain #(.WINDOW_MAX(WINDOW_MAX)) u_chain (
    .clk(clk), .ctl(ctl), .new_val(new_val), .count(count), .median(chain_med)
  );

  logic [IW-1:0] slot_wr;
  logic [CW-1:0] slot_inc;
  always_comb begin
    slot_wr = (CW'(write_slot) >= len) ? '0 : write_slot;
    slot_inc = CW'(slot_wr) + CW'(1);
  end

  logic signed [VAL_W-1:0] distance;
  logic [DEV_W+THR_W-1:0] prod;
  always_comb begin
    distance = VAL_W'(cur) - med;
    if (distance < 0) distance = -distance;
    prod = DEV_W'(mad) * threshold;
  end

  assign sample_stall = (state != S_IDLE) || (filtered_valid && filtered_stall);

  always_ff @(posedge clk) begin
    if (filtered_valid && !filtered_stall) filtered_valid <= 1'b0;
    case (state)
      S_IDLE: begin
        if (sample_valid && !sample_stall) begin
          cur <= sample;
          window_store[slot_wr] <= sample;
          idx <= '0;
          if (slot_inc >= len) begin
            write_slot <= '0;
            window_full <= 1'b1;
            count <= len;
            if (len >= CW'(2)) state <= S_SORT1;
            else begin
              filtered <= sample;
              filtered_valid <= 1'b1;
            end
          end else begin
            write_slot <= slot_inc[IW-1:0];
            count <= window_full ? len : slot_inc;
            if (window_full || slot_inc >= CW'(2)) state <= S_SORT1;
            else begin
              filtered <= sample;
              filtered_valid <= 1'b1;
            end
          end
        end
      end
      S_SORT1: begin
        idx <= idx + CW'(1);
        if (idx == count - CW'(1)) state <= S_MED1;
      end
      S_MED1: begin
        med <= chain_med;
        idx <= '0;
        state <= S_SORT2;
      end
      S_SORT2: begin
        idx <= idx + CW'(1);
        if (idx == count - CW'(1)) state <= S_MED2;
      end
      S_MED2: begin
        mad <= chain_med;
        state <= S_DONE;
      end
      S_DONE: begin
        filtered <= ((DEV_W+THR_W)'(distance) > prod) ? med[SAMPLE_W-1:0] : cur;
        filtered_valid <= 1'b1;
        state <= S_IDLE;
      end
      default: state <= S_IDLE;
    endcase
    if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          window_length <= cfg_data[LEN_W-1:0];
          write_slot <= '0;
          window_full <= 1'b0;
        end
        REG_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      state <= S_IDLE;
      filtered_valid <= 1'b0;
      window_length <= LEN_W'(LEN_RESET);
      threshold <= THR_W'(THR_RESET);
      write_slot <= '0;
      window_full <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### src/hof_sort_cell.sv
//==============================================================================
// hof_sort_cell
// one slot of an insertion sorting chain; values stay ascending along the row
//==============================================================================
`default_nettype none
module hof_sort_cell (
  input  wire                          clk,
  input  wire hof_pkg::cell_ctl_t      ctl,
  input  wire signed [hof_pkg::VAL_W-1:0] new_val,
  input  wire signed [hof_pkg::VAL_W-1:0] prev_val,
  input  wire                          prev_used,
  input  wire                          prev_gt,
  output logic signed [hof_pkg::VAL_W-1:0] val,
  output logic                         used,
  output logic                         gt
);
  import hof_pkg::*;

  // gt: this cell holds a value greater than the new one (or is empty)
  assign gt = !used || (val > new_val);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      used <= 1'b0;
    end else if (ctl.push) begin
      if (gt) begin
        if (prev_gt) begin
          // empty neighbor means this cell stays empty
          if (prev_used) begin
            used <= 1'b1;
            val <= prev_val;
          end
        end else begin
          used <= 1'b1;
          val <= new_val;
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/hof_sort_chain.sv
//==============================================================================
// hof_sort_chain
// row of sorting cells, one value inserted per cycle, median read at the end
//==============================================================================
`default_nettype none
module hof_sort_chain #(
  parameter int WINDOW_MAX = hof_pkg::WINDOW_MAX_DEF
) (
  input  wire                              clk,
  input  wire hof_pkg::cell_ctl_t          ctl,
  input  wire signed [hof_pkg::VAL_W-1:0]  new_val,
  input  wire [$clog2(WINDOW_MAX+1)-1:0]   count,
  output logic signed [hof_pkg::VAL_W-1:0] median
);
  import hof_pkg::*;
  localparam int CW = $clog2(WINDOW_MAX+1);
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic signed [VAL_W-1:0] vals [WINDOW_MAX];
  logic                    used [WINDOW_MAX];
  logic                    gts  [WINDOW_MAX];

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    hof_sort_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_val  (new_val),
      .prev_val ((k == 0) ? vals[0] : vals[(k == 0) ? 0 : k-1]),
      .prev_used((k == 0) ? 1'b0 : used[(k == 0) ? 0 : k-1]),
      .prev_gt  ((k == 0) ? 1'b0 : gts[(k == 0) ? 0 : k-1]),
      .val      (vals[k]),
      .used     (used[k]),
      .gt       (gts[k])
    );
  end

  logic [CW-1:0] hi_idx, lo_idx;
  logic signed [VAL_W:0] sum;
  always_comb begin
    hi_idx = count >> 1;
    lo_idx = (count[0]) ? hi_idx : hi_idx - CW'(1);
    sum = VAL_W'(0) + {vals[lo_idx[IW-1:0]][VAL_W-1], vals[lo_idx[IW-1:0]]}
          + {vals[hi_idx[IW-1:0]][VAL_W-1], vals[hi_idx[IW-1:0]]};
    median = sum[VAL_W:1];
  end
endmodule
`default_nettype wire
